// ===== hdl/ctpa_pkg.sv =====
`timescale 1ns / 1ps
package ctpa_pkg;

  localparam int COEFF_DEPTH_DEF  = 4096;
  localparam int MAX_VELOCITY_DEF = 3;

  localparam int LANES    = 3;
  localparam int IDX_W    = 12;
  localparam int Q_W      = 32;
  localparam int SUM_W    = 48;
  localparam int P_W      = 51;
  localparam int GAMMA_W  = 18;
  localparam int VCOUNT_W = 2;
  localparam int CFG_W    = 18;

  localparam logic [GAMMA_W-1:0]  GAMMA_RESET  = 18'd26214;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 2'd3;

  // one quotient bit per divider stage, plus input and output registers
  localparam int DIV_STEPS = 31;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    CFG_GAMMA  = 1'b0,
    CFG_VCOUNT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [IDX_W-1:0]      coeff_index;
    logic signed [Q_W-1:0] density;
    logic signed [Q_W-1:0] momentum_x;
    logic signed [Q_W-1:0] momentum_y;
    logic signed [Q_W-1:0] momentum_z;
    logic signed [Q_W-1:0] total_energy;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [SUM_W-1:0] density_total;
    logic signed [SUM_W-1:0] velocity_x_total;
    logic signed [SUM_W-1:0] velocity_y_total;
    logic signed [SUM_W-1:0] velocity_z_total;
    logic signed [SUM_W-1:0] pressure_total;
    logic                    bad_density;
    logic                    saturated;
  } out_t;

  // addends for one index, handed from the front to the accumulator
  typedef struct packed {
    logic                      in_range;
    logic [IDX_W-1:0]          index;
    logic                      bad;
    logic signed [Q_W-1:0]     density;
    logic [LANES-1:0][Q_W-1:0] vel;
    logic [LANES-1:0]          v_en;
    logic                      p_en;
    logic signed [P_W-1:0]     pressure;
  } work_t;

endpackage

// ===== hdl/ctpa_ram.sv =====
`timescale 1ns / 1ps
module ctpa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ctpa_div.sv =====
`timescale 1ns / 1ps
module ctpa_div import ctpa_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [Q_W-1:0] m,
  input  logic [Q_W-2:0]        d,
  output logic signed [Q_W-1:0] u
);

  // (|m| << 16) / d, one quotient bit per stage; quotients of 2^31 or more
  // are caught up front and clip
  logic [Q_W-1:0] r    [DIV_STEPS+1];
  logic [Q_W-2:0] nrem [DIV_STEPS+1];
  logic [Q_W-2:0] q    [DIV_STEPS+1];
  logic [Q_W-2:0] dv   [DIV_STEPS+1];
  logic           neg  [DIV_STEPS+1];
  logic           ovf  [DIV_STEPS+1];
  logic [Q_W-1:0] mag;

  assign mag = m[Q_W-1] ? Q_W'(-m) : Q_W'(m);

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]    <= {15'd0, mag[31:15]};
      nrem[0] <= {mag[14:0], 16'd0};
      q[0]    <= '0;
      dv[0]   <= d;
      neg[0]  <= m[Q_W-1];
      ovf[0]  <= {14'd0, mag} >= {d, 15'd0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [Q_W-1:0] sh;
    logic [Q_W:0]   diff;
    assign sh   = {r[k][Q_W-2:0], nrem[k][Q_W-2]};
    assign diff = {1'b0, sh} - {2'b00, dv[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[Q_W]) begin
          r[k+1] <= diff[Q_W-1:0];
          q[k+1] <= {q[k][Q_W-3:0], 1'b1};
        end else begin
          r[k+1] <= sh;
          q[k+1] <= {q[k][Q_W-3:0], 1'b0};
        end
        nrem[k+1] <= {nrem[k][Q_W-3:0], 1'b0};
        dv[k+1]   <= dv[k];
        neg[k+1]  <= neg[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[DIV_STEPS]) begin
        u <= neg[DIV_STEPS] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (neg[DIV_STEPS]) begin
        u <= -$signed({1'b0, q[DIV_STEPS]});
      end else begin
        u <= $signed({1'b0, q[DIV_STEPS]});
      end
    end
  end

endmodule

// ===== hdl/ctpa_front.sv =====
`timescale 1ns / 1ps
module ctpa_front import ctpa_pkg::*; #(
  parameter int COEFF_DEPTH  = COEFF_DEPTH_DEF,
  parameter int MAX_VELOCITY = MAX_VELOCITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_t                 in_data,
  input  logic [GAMMA_W-1:0]  gamma,
  input  logic [VCOUNT_W-1:0] vcount,
  input  logic                hold,
  output logic                out_valid,
  input  logic                out_ready,
  output work_t               out_data
);

  typedef struct packed {
    logic                      in_range;
    logic [IDX_W-1:0]          index;
    logic                      bad;
    logic signed [Q_W-1:0]     density;
    logic [LANES-1:0][Q_W-1:0] mom;
    logic [LANES-1:0][Q_W-1:0] vel;
    logic signed [Q_W-1:0]     energy;
    logic [LANES-1:0]          v_en;
    logic                      p_en;
  } ctx_t;

  logic en, accept;
  logic [VCOUNT_W-1:0] used;
  ctx_t ctx_in;
  ctx_t dl [DIV_LAT];
  logic [DIV_LAT-1:0] dl_valid;
  logic signed [Q_W-1:0] u [LANES];
  logic signed [63:0] prod_c [LANES];

  ctx_t s1_c;
  ctx_t s1, s2, s3, s4;
  logic [3:0] sv;
  logic signed [63:0] s1_prod [LANES];
  logic [63:0] kin_c;
  logic signed [48:0] d_c, s2_d;
  logic s3_neg, s4_neg;
  logic [47:0] s3_mag;
  logic [41:0] s4_ph, s4_pl;
  logic [65:0] total_c;
  logic [49:0] r_c;

  // whole pipeline moves together; a stall only comes from the queue
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !hold;
  assign accept   = in_valid && in_ready;

  assign used = (vcount > VCOUNT_W'(MAX_VELOCITY)) ? VCOUNT_W'(MAX_VELOCITY) : vcount;

  always_comb begin
    ctx_in.index    = in_data.coeff_index;
    ctx_in.in_range = {20'd0, in_data.coeff_index} < 32'(COEFF_DEPTH);
    ctx_in.bad      = in_data.density[Q_W-1] || (in_data.density == '0);
    ctx_in.density  = in_data.density;
    ctx_in.mom[0]   = in_data.momentum_x;
    ctx_in.mom[1]   = in_data.momentum_y;
    ctx_in.mom[2]   = in_data.momentum_z;
    ctx_in.vel      = '0;
    ctx_in.energy   = in_data.total_energy;
    ctx_in.p_en     = ctx_in.in_range && !ctx_in.bad;
    for (int i = 0; i < LANES; i++) begin
      ctx_in.v_en[i] = ctx_in.p_en && (VCOUNT_W'(i) < used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid <= '0;
      sv       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      dl_valid  <= {dl_valid[DIV_LAT-2:0], accept};
      sv        <= {sv[2:0], dl_valid[DIV_LAT-1]};
      out_valid <= sv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= ctx_in;
      for (int k = 1; k < DIV_LAT; k++) dl[k] <= dl[k-1];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < MAX_VELOCITY) begin : g_div
      ctpa_div u_div (
        .clk (clk),
        .en  (en),
        .m   (ctx_in.mom[i]),
        .d   (in_data.density[Q_W-2:0]),
        .u   (u[i])
      );
    end else begin : g_none
      assign u[i] = '0;
    end
    assign prod_c[i] = $signed(dl[DIV_LAT-1].mom[i]) * u[i];
  end

  // context leaving the delay line, with the quotients merged in
  always_comb begin
    s1_c = dl[DIV_LAT-1];
    for (int i = 0; i < LANES; i++) s1_c.vel[i] = u[i];
  end

  always_comb begin
    kin_c = '0;
    for (int i = 0; i < LANES; i++) kin_c = kin_c + 64'(s1_prod[i]);
    d_c     = 49'(s1.energy) - $signed({2'b00, kin_c[63:17]});
    total_c = {s4_ph, 24'd0} + 66'(s4_pl);
    r_c     = total_c[65:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_c;
      for (int i = 0; i < LANES; i++) begin
        s1_prod[i] <= dl[DIV_LAT-1].v_en[i] ? prod_c[i] : 64'sd0;
      end
      s2   <= s1;
      s2_d <= d_c;
      s3     <= s2;
      s3_neg <= s2_d[48];
      s3_mag <= s2_d[48] ? 48'(-s2_d) : 48'(s2_d);
      s4     <= s3;
      s4_neg <= s3_neg;
      s4_ph  <= 42'(gamma) * 42'(s3_mag[47:24]);
      s4_pl  <= 42'(gamma) * 42'(s3_mag[23:0]);
      out_data.in_range <= s4.in_range;
      out_data.index    <= s4.index;
      out_data.bad      <= s4.bad;
      out_data.density  <= s4.density;
      out_data.vel      <= s4.vel;
      out_data.v_en     <= s4.v_en;
      out_data.p_en     <= s4.p_en;
      out_data.pressure <= s4_neg ? -$signed({1'b0, r_c}) : $signed({1'b0, r_c});
    end
  end

endmodule

// ===== hdl/ctpa_queue.sv =====
`timescale 1ns / 1ps
module ctpa_queue import ctpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic push, pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hdl/ctpa_back.sv =====
`timescale 1ns / 1ps
module ctpa_back import ctpa_pkg::*; #(
  parameter int COEFF_DEPTH  = COEFF_DEPTH_DEF,
  parameter int MAX_VELOCITY = MAX_VELOCITY_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data,
  output logic  clearing
);

  localparam int ADDR_W = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;
  localparam int WORD_W = SUM_W * (MAX_VELOCITY + 2);
  localparam int P_OFS  = SUM_W * (MAX_VELOCITY + 1);

  logic a_valid, a_adv, pop;
  work_t a_item;
  logic [ADDR_W-1:0] a_addr, clr_addr;
  logic [WORD_W-1:0] rdata, old_word, new_word;
  logic last_valid;
  logic [ADDR_W-1:0] last_addr;
  logic [WORD_W-1:0] last_data;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic sat_any;
  logic [SUM_W:0] acc;
  logic [LANES-1:0][SUM_W-1:0] vel_tot;

  // returns {clipped, sum}
  function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] base,
                                             input logic signed [P_W-1:0] add);
    logic signed [P_W:0] s;
    logic [SUM_W:0] res;
    s = (P_W+1)'(base) + (P_W+1)'(add);
    if (&s[P_W:SUM_W-1] || ~|s[P_W:SUM_W-1]) begin
      res = {1'b0, s[SUM_W-1:0]};
    end else if (s[P_W]) begin
      res = {1'b1, 1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(SUM_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign a_adv    = a_valid && (!out_valid || out_ready);
  assign pop      = !clearing && (!a_valid || a_adv);
  assign in_ready = pop;
  assign a_addr   = ADDR_W'(a_item.index);

  // the read for an item can race the write of the one before; take the
  // newest written word for that address
  assign old_word = (last_valid && last_addr == a_addr) ? last_data : rdata;

  always_comb begin
    new_word = old_word;
    sat_any  = 1'b0;
    acc = sat_add(old_word[SUM_W-1:0], P_W'(a_item.density));
    if (a_item.in_range) begin
      new_word[SUM_W-1:0] = acc[SUM_W-1:0];
      sat_any = sat_any | acc[SUM_W];
    end
    for (int i = 0; i < MAX_VELOCITY; i++) begin
      acc = sat_add(old_word[SUM_W*(i+1) +: SUM_W], P_W'($signed(a_item.vel[i])));
      if (a_item.v_en[i]) begin
        new_word[SUM_W*(i+1) +: SUM_W] = acc[SUM_W-1:0];
        sat_any = sat_any | acc[SUM_W];
      end
    end
    acc = sat_add(old_word[P_OFS +: SUM_W], a_item.pressure);
    if (a_item.p_en) begin
      new_word[P_OFS +: SUM_W] = acc[SUM_W-1:0];
      sat_any = sat_any | acc[SUM_W];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_vtot
    if (i < MAX_VELOCITY) begin : g_used
      assign vel_tot[i] = new_word[SUM_W*(i+1) +: SUM_W];
    end else begin : g_zero
      assign vel_tot[i] = '0;
    end
  end

  assign we    = clearing || (a_adv && a_item.in_range);
  assign waddr = clearing ? clr_addr : a_addr;
  assign wdata = clearing ? '0 : new_word;

  ctpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (COEFF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop && in_valid),
    .raddr (ADDR_W'(in_data.index)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
      last_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == ADDR_W'(COEFF_DEPTH - 1)) clearing <= 1'b0;
        clr_addr <= clr_addr + 1'b1;
      end
      if (pop) a_valid <= in_valid;
      if (a_adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (a_adv && a_item.in_range) last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && in_valid) a_item <= in_data;
    if (a_adv && a_item.in_range) begin
      last_addr <= a_addr;
      last_data <= new_word;
    end
    if (a_adv) begin
      out_data.out_index <= a_item.index;
      if (a_item.in_range) begin
        out_data.density_total    <= new_word[SUM_W-1:0];
        out_data.velocity_x_total <= vel_tot[0];
        out_data.velocity_y_total <= vel_tot[1];
        out_data.velocity_z_total <= vel_tot[2];
        out_data.pressure_total   <= new_word[P_OFS +: SUM_W];
        out_data.bad_density      <= a_item.bad;
        out_data.saturated        <= sat_any;
      end else begin
        out_data.density_total    <= '0;
        out_data.velocity_x_total <= '0;
        out_data.velocity_y_total <= '0;
        out_data.velocity_z_total <= '0;
        out_data.pressure_total   <= '0;
        out_data.bad_density      <= 1'b0;
        out_data.saturated        <= 1'b0;
      end
    end
  end

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> !clearing) else $error("item in flight during clearing pass");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> out_valid) else $error("accumulated result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !a_adv) else $error("result overwritten while stalled");

  a_clear_clean: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> !last_valid && !a_valid && !out_valid)
    else $error("state not clean after clearing pass");

endmodule

// ===== hdl/conservative_to_primitive_accumulator.sv =====
`timescale 1ns / 1ps
// Converts conservative samples (density, momentum, energy, Q16.16) into
// velocity and pressure and keeps saturating 48-bit running sums of density,
// velocity and pressure per coefficient index, returning the updated sums
// for every in-range transfer (zeros for an out-of-range index). One item is
// taken per clock unless back-pressure or the clearing pass stalls; items
// pass through the bit-per-stage velocity dividers, registered kinetic and
// pressure math, the queue and a read-modify-write of the sum memory. The
// per-cycle rate is set by the single sum memory, which does one read and
// one write each cycle with the newest write forwarded. After reset the sum
// memory is cleared, during which in_ready stays low; configuration writes
// are taken at any time but should only be made while the block is idle.
module conservative_to_primitive_accumulator import ctpa_pkg::*; #(
  parameter int COEFF_DEPTH  = COEFF_DEPTH_DEF,
  parameter int MAX_VELOCITY = MAX_VELOCITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [GAMMA_W-1:0]  gamma_minus_one;
  logic [VCOUNT_W-1:0] velocity_count;
  logic clearing;
  logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  work_t q_push_data, q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_minus_one <= GAMMA_RESET;
      velocity_count  <= VCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GAMMA:  gamma_minus_one <= cfg_data[GAMMA_W-1:0];
        CFG_VCOUNT: velocity_count  <= cfg_data[VCOUNT_W-1:0];
      endcase
    end
  end

  ctpa_front #(
    .COEFF_DEPTH  (COEFF_DEPTH),
    .MAX_VELOCITY (MAX_VELOCITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .gamma     (gamma_minus_one),
    .vcount    (velocity_count),
    .hold      (clearing),
    .out_valid (q_push_valid),
    .out_ready (q_push_ready),
    .out_data  (q_push_data)
  );

  ctpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  ctpa_back #(
    .COEFF_DEPTH  (COEFF_DEPTH),
    .MAX_VELOCITY (MAX_VELOCITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_pop_valid),
    .in_ready  (q_pop_ready),
    .in_data   (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .clearing  (clearing)
  );

endmodule
